// ===== sv/psr_pkg.sv =====
// Package for polynomial surface reconstruction.
// Holds widths, codes, degree tables, the job record and the back-end state type.
// No dependencies.
package psr_pkg;

  localparam int MAX_DIM  = 256;
  localparam int POS_W    = $clog2(MAX_DIM);
  localparam int DIM_W    = POS_W + 1;
  localparam int CFG_W    = 9;
  localparam int COORD_W  = POS_W + 2;
  localparam int DEN_W    = 3 * POS_W;
  localparam int ACC_W    = 33 + 3 * POS_W;
  localparam int MAG_W    = ACC_W - 1;
  localparam int SCALE_SH = 14;
  localparam int DV_W     = DEN_W + SCALE_SH;
  localparam int CNT_W    = $clog2(MAG_W);
  localparam int NCOEF    = 10;
  localparam int IDX_W    = 4;
  localparam int MARK_W   = NCOEF + 1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RES  = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_ORDER   = 2'd1;
  localparam logic [1:0] ERR_MISSING = 2'd2;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_MUL,
    BK_DIV,
    BK_ACC,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic                      is_load;
    logic [IDX_W-1:0]          coef_idx;
    logic [31:0]               value;
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
    logic [POS_W-1:0]          su;
    logic [POS_W-1:0]          sv;
    logic [IDX_W-1:0]          nterms;
    logic [1:0]                err;
    logic                      last;
  } job_t;

  function automatic logic [1:0] deg_u(input logic [IDX_W-1:0] k);
    logic [1:0] d;
    case (k)
      4'd1, 4'd4, 4'd8: d = 2'd1;
      4'd3, 4'd7:       d = 2'd2;
      4'd6:             d = 2'd3;
      default:          d = 2'd0;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] deg_v(input logic [IDX_W-1:0] k);
    logic [1:0] d;
    case (k)
      4'd2, 4'd4, 4'd7: d = 2'd1;
      4'd5, 4'd8:       d = 2'd2;
      4'd9:             d = 2'd3;
      default:          d = 2'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== sv/psr_queue.sv =====
// Two-entry job queue between front and back ends.
// Depends on psr_pkg (job_t).
module psr_queue import psr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t pop_data
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= push_data;
  end

endmodule

// ===== sv/psr_front.sv =====
// Front end: block size registers, load marks, order word and raster position.
// Turns coefficient loads and residuals into jobs for the back end. Depends on psr_pkg.
module psr_front import psr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_push,
  input  logic             in_cmd,
  input  logic [IDX_W-1:0] in_param_index,
  input  logic [31:0]      in_param_value,
  input  logic [31:0]      in_residual,
  input  logic             q_full,
  output logic             q_push,
  output job_t             q_data
);

  logic [CFG_W-1:0]  cfg_w_r, cfg_h_r;
  logic [POS_W-1:0]  col_r, row_r, col_nxt, row_nxt;
  logic [MARK_W-1:0] marks_r, marks_nxt, need;
  logic [31:0]       order_r, order_nxt;
  logic [DIM_W-1:0]  w, h;
  logic [POS_W-1:0]  wm1, hm1, x, y;
  logic              accept, last_col, last_row;
  logic [IDX_W-1:0]  nterms;
  logic [1:0]        err;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) r = DIM_W'(1);
    else if (int'(d) > MAX_DIM) r = DIM_W'(MAX_DIM);
    else r = DIM_W'(d);
    return r;
  endfunction

  always_comb begin
    w        = eff_dim(cfg_w_r);
    h        = eff_dim(cfg_h_r);
    wm1      = POS_W'(w - DIM_W'(1));
    hm1      = POS_W'(h - DIM_W'(1));
    x        = (DIM_W'(col_r) < w) ? col_r : wm1;
    y        = (DIM_W'(row_r) < h) ? row_r : hm1;
    last_col = (x == wm1);
    last_row = (y == hm1);
    accept   = in_push && !q_full;

    nterms = '0;
    need   = '0;
    err    = ERR_OK;
    if (!marks_r[0]) begin
      err = ERR_ORDER;
    end else begin
      case (order_r)
        32'd1:   begin nterms = 4'd3;  need = MARK_W'(11'h00E); end
        32'd2:   begin nterms = 4'd6;  need = MARK_W'(11'h07E); end
        32'd3:   begin nterms = 4'd10; need = MARK_W'(11'h7FE); end
        default: err = ERR_ORDER;
      endcase
      if (err == ERR_OK && (marks_r & need) != need) err = ERR_MISSING;
    end

    q_data.is_load  = (in_cmd == CMD_LOAD);
    q_data.coef_idx = in_param_index;
    q_data.value    = (in_cmd == CMD_LOAD) ? in_param_value : in_residual;
    q_data.u        = $signed({1'b0, x, 1'b0}) - $signed({2'b00, wm1});
    q_data.v        = $signed({1'b0, y, 1'b0}) - $signed({2'b00, hm1});
    q_data.su       = (w > DIM_W'(1)) ? wm1 : POS_W'(1);
    q_data.sv       = (h > DIM_W'(1)) ? hm1 : POS_W'(1);
    q_data.nterms   = nterms;
    q_data.err      = err;
    q_data.last     = last_col && last_row;

    q_push    = 1'b0;
    col_nxt   = col_r;
    row_nxt   = row_r;
    marks_nxt = marks_r;
    order_nxt = order_r;
    if (accept) begin
      if (in_cmd == CMD_LOAD) begin
        if (in_param_index == '0) begin
          order_nxt  = in_param_value;
          marks_nxt[0] = 1'b1;
        end else if (int'(in_param_index) <= NCOEF) begin
          marks_nxt[in_param_index] = 1'b1;
          q_push = 1'b1;
        end
      end else begin
        q_push = 1'b1;
        if (last_col && last_row) begin
          col_nxt   = '0;
          row_nxt   = '0;
          marks_nxt = '0;
        end else if (last_col) begin
          col_nxt = '0;
          row_nxt = y + POS_W'(1);
        end else begin
          col_nxt = x + POS_W'(1);
          row_nxt = y;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= CFG_W'(1);
      cfg_h_r <= CFG_W'(1);
      col_r   <= '0;
      row_r   <= '0;
      marks_r <= '0;
      order_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH:  cfg_w_r <= cfg_wdata;
          CFG_HEIGHT: cfg_h_r <= cfg_wdata;
        endcase
      end
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      marks_r <= marks_nxt;
      order_r <= order_nxt;
    end
  end

endmodule

// ===== sv/psr_back.sv =====
// Back end: coefficient store, term sequencer with shared numerator and denominator multipliers and
// restoring divider, prediction accumulator and result register. Depends on psr_pkg.
module psr_back import psr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  job_t        q_data,
  output logic        q_pop,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [31:0] out_sample,
  output logic        out_last_of_block,
  output logic [1:0]  out_error_code
);

  bk_state_t                  state_r, state_nxt;
  job_t                       job_r, job_nxt;
  logic [31:0]                coef_r [NCOEF];
  logic                       coef_we;
  logic [IDX_W-1:0]           k_r, k_nxt;
  logic [1:0]                 j_r, j_nxt, du, dsum;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic [DEN_W-1:0]           den_r, den_nxt;
  logic [MAG_W-1:0]           mag_r, mag_nxt;
  logic [DV_W-1:0]            rem_r, rem_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       neg_r, neg_nxt;
  logic [31:0]                pred_r, pred_nxt;
  logic                       ov_r, ov_nxt, olast_r, olast_nxt;
  logic [31:0]                osmp_r, osmp_nxt;
  logic [1:0]                 oerr_r, oerr_nxt;
  logic signed [COORD_W-1:0]  fac;
  logic [POS_W-1:0]           dfac;
  logic signed [ACC_W+COORD_W-1:0] prod;
  logic [DEN_W+POS_W-1:0]     dprod;
  logic [DV_W:0]              sh, dv;
  logic [ACC_W-1:0]           absacc;

  assign out_empty         = !ov_r;
  assign out_sample        = osmp_r;
  assign out_last_of_block = olast_r;
  assign out_error_code    = oerr_r;

  always_comb begin
    du     = deg_u(k_r);
    dsum   = du + deg_v(k_r);
    fac    = (j_r < du) ? job_r.u : job_r.v;
    dfac   = (j_r < du) ? job_r.su : job_r.sv;
    prod   = acc_r * fac;
    dprod  = den_r * dfac;
    absacc = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    sh     = {rem_r, mag_r[MAG_W-1]};
    dv     = (DV_W+1)'({den_r, {SCALE_SH{1'b0}}});

    state_nxt = state_r;
    job_nxt   = job_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    acc_nxt   = acc_r;
    den_nxt   = den_r;
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    pred_nxt  = pred_r;
    q_pop     = 1'b0;
    coef_we   = 1'b0;
    ov_nxt    = ov_r && !out_pop;
    osmp_nxt  = osmp_r;
    olast_nxt = olast_r;
    oerr_nxt  = oerr_r;

    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_data;
          if (q_data.is_load) begin
            coef_we = 1'b1;
          end else if (q_data.err != ERR_OK) begin
            state_nxt = BK_OUT;
          end else begin
            k_nxt     = '0;
            pred_nxt  = '0;
            state_nxt = BK_LOAD;
          end
        end
      end
      BK_LOAD: begin
        acc_nxt   = ACC_W'($signed(coef_r[k_r]));
        den_nxt   = DEN_W'(1);
        j_nxt     = '0;
        state_nxt = BK_MUL;
      end
      BK_MUL: begin
        if (j_r == dsum) begin
          neg_nxt   = acc_r[ACC_W-1];
          mag_nxt   = absacc[MAG_W-1:0];
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = BK_DIV;
        end else begin
          acc_nxt = prod[ACC_W-1:0];
          den_nxt = dprod[DEN_W-1:0];
          j_nxt   = j_r + 2'd1;
        end
      end
      BK_DIV: begin
        if (sh >= dv) begin
          rem_nxt = DV_W'(sh - dv);
          mag_nxt = {mag_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_nxt = sh[DV_W-1:0];
          mag_nxt = {mag_r[MAG_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MAG_W-1)) state_nxt = BK_ACC;
      end
      BK_ACC: begin
        pred_nxt  = neg_r ? pred_r - mag_r[31:0] : pred_r + mag_r[31:0];
        k_nxt     = k_r + IDX_W'(1);
        state_nxt = (k_r + IDX_W'(1) == job_r.nterms) ? BK_OUT : BK_LOAD;
      end
      BK_OUT: begin
        if (!ov_r || out_pop) begin
          ov_nxt    = 1'b1;
          osmp_nxt  = (job_r.err == ERR_OK) ? job_r.value + pred_r : '0;
          olast_nxt = job_r.last;
          oerr_nxt  = job_r.err;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    k_r     <= k_nxt;
    j_r     <= j_nxt;
    acc_r   <= acc_nxt;
    den_r   <= den_nxt;
    mag_r   <= mag_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    pred_r  <= pred_nxt;
    osmp_r  <= osmp_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
    if (coef_we) coef_r[q_data.coef_idx - IDX_W'(1)] <= q_data.value;
  end

endmodule

// ===== sv/polynomial_surface_reconstruct_top.sv =====
// Top level of polynomial surface reconstruction.
// Instantiates psr_front, psr_queue and psr_back; depends on psr_pkg.
//
//  channel | direction | handshake        | payload
//  cfg     | in        | cfg_we           | cfg_index, cfg_wdata
//  in      | in        | in_push/in_full  | cmd, param_index, param_value, residual
//  out     | out       | out_pop/out_empty| sample, last_of_block, error_code
//
// Order words and ignored loads end in the front end; coefficient loads are written
// by the back end from idle. A residual in error goes straight to the output state; a
// good one runs, per term, load, multiply, a 56-step shared divide and accumulate.
// Synchronous active-low reset; no clearing pass. Front and back stall separately
// through a two-entry queue; one finished result waits in the output register.
module polynomial_surface_reconstruct_top import psr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_cmd,
  input  logic [IDX_W-1:0] in_param_index,
  input  logic [31:0]      in_param_value,
  input  logic [31:0]      in_residual,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [31:0]      out_sample,
  output logic             out_last_of_block,
  output logic [1:0]       out_error_code
);

  logic q_push, q_full, q_pop, q_empty;
  job_t q_in, q_out;

  assign in_full = q_full;

  psr_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_push, .in_cmd, .in_param_index, .in_param_value, .in_residual,
    .q_full, .q_push, .q_data(q_in)
  );

  psr_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_out)
  );

  psr_back u_back (
    .clk, .rst_n, .q_empty, .q_data(q_out), .q_pop,
    .out_pop, .out_empty, .out_sample, .out_last_of_block, .out_error_code
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_error_code != ERR_OK) |-> out_sample == '0)
    else $error("error result with nonzero sample");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_error_code == ERR_OK || out_error_code == ERR_ORDER ||
                    out_error_code == ERR_MISSING))
    else $error("undefined error code");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("not empty after reset");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for polynomial_surface_reconstruct_top.
// Queue-fed driver and monitor with an in-bench surface predictor and block-size shadow.
// Depends on psr_pkg and the RTL of polynomial_surface_reconstruct_top.
`timescale 1ns / 100ps

module tb_top;
  import psr_pkg::*;

  typedef struct {
    logic             cmd;
    logic [IDX_W-1:0] idx;
    logic [31:0]      value;
    logic [31:0]      residual;
  } xact_t;

  typedef struct {
    logic [31:0] sample;
    logic        last;
    logic [1:0]  err;
  } sample_t;

  localparam int WATCHDOG = 20000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_push = 1'b0;
  logic             in_full;
  logic             in_cmd = CMD_LOAD;
  logic [IDX_W-1:0] in_param_index = '0;
  logic [31:0]      in_param_value = '0;
  logic [31:0]      in_residual = '0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic [31:0]      out_sample;
  logic             out_last_of_block;
  logic [1:0]       out_error_code;

  polynomial_surface_reconstruct_top u_top (.*);

  always #6 clk = ~clk;

  xact_t   pending_xacts[$];
  sample_t expected_samples[$];
  int      fail_count = 0;
  int      idle_cycles = 0;
  bit      in_taken = 1'b0;
  int      tx_gap = 0;
  int      rx_gap = 0;
  int      rx_hold = 0;
  bit      no_idle = 1'b0;

  // predictor state
  logic [CFG_W-1:0] width_reg = 9'd1;
  logic [CFG_W-1:0] height_reg = 9'd1;
  logic [31:0]      order_word = '0;
  logic [31:0]      coef_mem[NCOEF];
  logic [MARK_W-1:0] marks = '0;
  int               col_pos = 0;
  int               row_pos = 0;
  const int         pow_u[NCOEF] = '{0, 1, 0, 2, 1, 0, 3, 2, 1, 0};
  const int         pow_v[NCOEF] = '{0, 0, 1, 0, 1, 2, 0, 1, 2, 3};

  function automatic int clamp_dim(logic [CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  function automatic void reconstruct_step(xact_t t);
    int w, h, x, y, nterms;
    logic [1:0] err;
    logic [MARK_W-1:0] need;
    longint u, v, su, sv, pred, term, den;
    sample_t r;
    if (t.cmd == CMD_LOAD) begin
      if (t.idx == 0) order_word = t.value;
      else if (t.idx <= NCOEF) coef_mem[t.idx-1] = t.value;
      else return;
      marks[t.idx] = 1'b1;
      return;
    end
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    x = col_pos < w ? col_pos : w - 1;
    y = row_pos < h ? row_pos : h - 1;
    err = ERR_OK;
    nterms = 0;
    if (!marks[0]) err = ERR_ORDER;
    else if (order_word == 1) nterms = 3;
    else if (order_word == 2) nterms = 6;
    else if (order_word == 3) nterms = 10;
    else err = ERR_ORDER;
    if (err == ERR_OK) begin
      need = ((MARK_W'(1) << nterms) - 1) << 1;
      if ((marks & need) != need) err = ERR_MISSING;
    end
    r.sample = '0;
    if (err == ERR_OK) begin
      u = 2 * x - (w - 1);
      v = 2 * y - (h - 1);
      su = w > 1 ? w - 1 : 1;
      sv = h > 1 ? h - 1 : 1;
      pred = 0;
      for (int k = 0; k < nterms; k++) begin
        term = longint'($signed(coef_mem[k]));
        den = 16384;
        for (int d = 0; d < pow_u[k]; d++) begin
          term *= u;
          den *= su;
        end
        for (int d = 0; d < pow_v[k]; d++) begin
          term *= v;
          den *= sv;
        end
        pred += term / den;
      end
      r.sample = t.residual + pred[31:0];
    end
    r.last = (x >= w - 1) && (y >= h - 1);
    r.err = err;
    if (r.last) begin
      col_pos = 0;
      row_pos = 0;
      marks = '0;
    end else if (x >= w - 1) begin
      col_pos = 0;
      row_pos = y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
    expected_samples = {expected_samples, r};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sender
  always @(negedge clk) begin
    bit push_next;
    push_next = in_push;
    if (!rst_n) begin
      push_next = 1'b0;
    end else if (!(in_push && !in_taken)) begin
      push_next = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pending_xacts.size() > 0) begin
        in_cmd         <= pending_xacts[0].cmd;
        in_param_index <= pending_xacts[0].idx;
        in_param_value <= pending_xacts[0].value;
        in_residual    <= pending_xacts[0].residual;
        void'(pending_xacts.pop_front());
        push_next = 1'b1;
        tx_gap = pick_gap();
      end
    end
    in_push <= push_next;
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_pop <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      rx_gap = pick_gap();
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    xact_t t;
    sample_t e;
    in_taken = 1'b0;
    if (rst_n) begin
      idle_cycles++;
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) width_reg = cfg_wdata;
        else height_reg = cfg_wdata;
        idle_cycles = 0;
      end
      if (in_push && !in_full) begin
        in_taken = 1'b1;
        t.cmd = in_cmd;
        t.idx = in_param_index;
        t.value = in_param_value;
        t.residual = in_residual;
        reconstruct_step(t);
        idle_cycles = 0;
      end
      if (out_pop && !out_empty) begin
        idle_cycles = 0;
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected transaction", out_sample, 32'h0);
        end else begin
          e = expected_samples.pop_front();
          if (out_sample !== e.sample) report_mismatch("sample", out_sample, e.sample);
          if (out_last_of_block !== e.last)
            report_mismatch("last_of_block", {31'b0, out_last_of_block}, {31'b0, e.last});
          if (out_error_code !== e.err)
            report_mismatch("error_code", {30'b0, out_error_code}, {30'b0, e.err});
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("polynomial_surface_reconstruct_top test failed");
        $finish;
      end
    end
  end

  int sent = 0;
  int big_blocks = 0;

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_xact(logic cmd, int idx, logic [31:0] value, logic [31:0] residual);
    xact_t t;
    t.cmd = cmd;
    t.idx = IDX_W'(idx);
    t.value = value;
    t.residual = residual;
    pending_xacts = {pending_xacts, t};
    if (cmd == CMD_RES || idx <= NCOEF) sent++;
  endtask

  task automatic add_load(int idx, logic [31:0] value);
    add_xact(CMD_LOAD, idx, value, $urandom);
  endtask

  task automatic add_residual(logic [31:0] residual);
    add_xact(CMD_RES, $urandom_range(0, 15), $urandom, residual);
  endtask

  task automatic wait_idle();
    while (pending_xacts.size() != 0 || in_push || expected_samples.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_block(int cells, bit allow_three);
    int r, ord, n;
    logic [31:0] ow;
    r = $urandom_range(0, 99);
    ord = r < 45 ? 1 : (r < 75 || !allow_three) ? 2 : 3;
    n = ord == 1 ? 3 : ord == 2 ? 6 : 10;
    ow = ord;
    r = $urandom_range(0, 99);
    if (r < 8) ow = $urandom_range(0, 1) ? 32'(4 + $urandom_range(0, 3)) : $urandom;
    if (r < 8 && $urandom_range(0, 1)) ow = 32'd0;
    if (r >= 8 && r < 12) begin
      // no order word at all
    end else begin
      add_load(0, ow);
    end
    for (int k = 1; k <= n; k++)
      if (!(r >= 12 && r < 20 && k == $urandom_range(1, n))) add_load(k, rand_word());
    if ($urandom_range(0, 9) == 0) add_load($urandom_range(11, 15), $urandom);
    if ($urandom_range(0, 9) == 0) cells = $urandom_range(1, cells);
    for (int i = 0; i < cells; i++) add_residual(rand_word());
  endtask

  initial begin
    int w, h, phase;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, 1x1 block after reset
    add_residual(32'h1234_5678);
    add_load(0, 32'd0);
    add_residual(32'h7fff_ffff);
    add_load(0, 32'd4);
    add_residual(32'h8000_0000);
    add_load(13, 32'hffff_ffff);
    add_load(0, 32'd1);
    add_load(1, 32'h7fff_ffff);
    add_load(2, 32'h8000_0000);
    add_residual(32'h0);
    add_load(0, 32'd3);
    for (int k = 1; k <= NCOEF; k++) add_load(k, k[0] ? 32'h8000_0000 : 32'h7fff_ffff);
    add_residual(32'h7fff_ffff);
    wait_idle();

    phase = 0;
    while (sent < 1950) begin
      w = $urandom_range(1, 5);
      h = $urandom_range(1, 5);
      case ($urandom_range(0, 19))
        0: w = 0;
        1: h = 0;
        2: if (big_blocks < 4) begin
          w = $urandom_range(0, 1) ? 511 : 300;
          h = 1;
          big_blocks++;
        end
        3: if (big_blocks < 4) begin
          w = $urandom_range(0, 1) ? 0 : 1;
          h = 256;
          big_blocks++;
        end
        default: ;
      endcase
      if (phase == 3) begin
        w = 4;
        h = 4;
      end
      write_reg(CFG_WIDTH, CFG_W'(w));
      write_reg(CFG_HEIGHT, CFG_W'(h));
      no_idle = ($urandom_range(0, 4) == 0);
      if (phase == 3) rx_hold = 2000;
      for (int b = 0; b < (clamp_dim(w) * clamp_dim(h) > 64 ? 1 : $urandom_range(1, 4)); b++)
        add_block(clamp_dim(w) * clamp_dim(h), clamp_dim(w) * clamp_dim(h) <= 64);
      wait_idle();
      phase++;
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("polynomial_surface_reconstruct_top test passed");
    end else begin
      $display("polynomial_surface_reconstruct_top test failed");
    end
    $finish;
  end

endmodule
